// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPLY(label, clk, rst_n, pre, con, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (con)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, pre, con, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (con)) \
        else $error(msg);

`endif

// ===== src/tsam_pkg.sv =====
package tsam_pkg;

    localparam int COORD_W      = 12;
    localparam int PRESS_W      = 12;
    localparam int LAST_W       = 11;
    localparam int CFG_IDX_W    = 3;
    localparam int ROT_W        = 2;
    localparam int PROD_W       = COORD_W + LAST_W;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 24;
    localparam int DEF_SAMPLES  = 4;
    localparam int MIN_VALID    = 2;
    localparam int COORD_HIGH_I = 4000;

    localparam logic [PRESS_W-1:0] TOUCH_THRESHOLD = 12'd100;
    localparam logic [COORD_W-1:0] COORD_LOW       = 12'd100;
    localparam logic [COORD_W-1:0] COORD_HIGH      = 12'd4000;
    localparam logic [COORD_W-1:0] SCREEN_LIMIT    = 12'd2048;

    localparam logic [COORD_W-1:0] RST_CAL_MIN = 12'd200;
    localparam logic [COORD_W-1:0] RST_CAL_MAX = 12'd3800;
    localparam logic [COORD_W-1:0] RST_WIDTH   = 12'd240;
    localparam logic [COORD_W-1:0] RST_HEIGHT  = 12'd320;

    localparam logic [CFG_IDX_W-1:0] REG_CAL_X_MIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_X_MAX     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_Y_MIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_Y_MAX     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION      = 3'd6;

    localparam logic [ROT_W-1:0] ROT_NONE = 2'd0;
    localparam logic [ROT_W-1:0] ROT_90   = 2'd1;
    localparam logic [ROT_W-1:0] ROT_180  = 2'd2;
    localparam logic [ROT_W-1:0] ROT_270  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_SETUP,
        ST_MUL,
        ST_DIV,
        ST_MAP,
        ST_DONE
    } state_t;

endpackage

// ===== src/touch_sample_average_map.sv =====
// Touch sample averaging and screen mapping.
// s_ channel: one touch sample per item (pressure, raw X, raw Y). A request
// ends on its SAMPLES_PER_REQUEST-th touched sample or on the first sample
// with pressure at most 100; only that last item yields a result.
// m_ channel: one result per request; tuser is the position-valid flag and
// tdata carries the rotated column and row (both zero when tuser is low).
// cfg_ channel: register writes (index, data), always ready; write only
// while the block is idle.
// A sample that does not end a request leaves the block idle. An ending
// sample with too few valid readings goes straight to the final step.
// Otherwise each axis runs a 23-step restoring divide for the
// average, an 11-step shift-add multiply and a 23-step divide for the
// mapping, one bit per cycle; both divides and both axes share one divider.
// No sample is taken during that time.
// A finished result sits in the output register; a stalled receiver holds
// the block in its final step until the register frees.
// Reset (aresetn low, synchronous) loads the default calibration and
// clears the request state and the output valid flag.
`include "assert_macros.svh"

module touch_sample_average_map
    import tsam_pkg::*;
#(
    parameter int SAMPLES_PER_REQUEST = DEF_SAMPLES
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // pressure_raw, sample_x, sample_y, zero pad
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // pos_x, pos_y, zero pad
    output logic                   m_tuser,   // position_valid
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [COORD_W-1:0]     cfg_data
);

    localparam int IDX_W = $clog2(SAMPLES_PER_REQUEST + 1);
    localparam int SUM_W = $clog2(SAMPLES_PER_REQUEST * (COORD_HIGH_I - 1) + 1);
    localparam int DIV_W = (SUM_W > PROD_W) ? SUM_W : PROD_W;
    localparam int CNT_W = $clog2(DIV_W);

    // configuration
    logic [COORD_W-1:0] cal_x_min_reg, cal_x_max_reg, cal_y_min_reg, cal_y_max_reg;
    logic [COORD_W-1:0] width_reg, height_reg;
    logic [ROT_W-1:0]   rotation_reg;

    // request state
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   vcnt_reg, vcnt_next;
    logic [SUM_W-1:0]   sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic               good_reg, good_next;
    logic               axis_reg, axis_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    // serial arithmetic
    logic [DIV_W-1:0]   quo_reg, quo_next;
    logic [COORD_W-1:0] rem_reg, rem_next;
    logic [COORD_W-1:0] den_reg, den_next;
    logic [COORD_W-1:0] mcand_reg, mcand_next;
    logic [LAST_W-1:0]  mlt_reg, mlt_next;
    logic               dneg_reg, dneg_next;
    logic               zero_reg, zero_next;
    logic               inv_reg, inv_next;
    logic [LAST_W-1:0]  sx_reg, sx_next, sy_reg, sy_next;

    // output register
    logic               m_tvalid_reg, m_tvalid_next;
    logic               m_tuser_reg, m_tuser_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [PRESS_W-1:0] s_pressure;
    logic [COORD_W-1:0] s_x, s_y;
    logic               s_fire, touched, take, done, enough, out_free;
    logic [IDX_W-1:0]   idx_inc, vcnt_acc;
    logic [SUM_W-1:0]   sum_x_acc, sum_y_acc;
    logic               cnt_div_end, cnt_mul_end;

    logic [LAST_W-1:0]  w_last, h_last, last_sel;
    logic [COORD_W-1:0] cmin_sel, cmax_sel, lo, hi, avg;
    logic               inv_sel;
    logic [COORD_W:0]   trial;
    logic               trial_ge;
    logic [LAST_W-1:0]  qsat, map_res;
    logic [LAST_W-1:0]  rx, ry;

    assign s_pressure = s_tdata[PRESS_W-1:0];
    assign s_x        = s_tdata[PRESS_W +: COORD_W];
    assign s_y        = s_tdata[PRESS_W+COORD_W +: COORD_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    // sample intake
    assign touched   = s_pressure > TOUCH_THRESHOLD;
    assign take      = touched && (s_x > COORD_LOW) && (s_x < COORD_HIGH)
                       && (s_y > COORD_LOW) && (s_y < COORD_HIGH);
    assign idx_inc   = idx_reg + IDX_W'(1);
    assign sum_x_acc = sum_x_reg + (take ? SUM_W'(s_x) : SUM_W'(0));
    assign sum_y_acc = sum_y_reg + (take ? SUM_W'(s_y) : SUM_W'(0));
    assign vcnt_acc  = vcnt_reg + IDX_W'(take);
    assign done      = !touched || (idx_inc >= IDX_W'(SAMPLES_PER_REQUEST));
    assign enough    = vcnt_acc >= IDX_W'(MIN_VALID);

    assign cnt_div_end = (cnt_reg == CNT_W'(DIV_W - 1));
    assign cnt_mul_end = (cnt_reg == CNT_W'(LAST_W - 1));

    // effective last column and row: zero size acts as one, oversize as the limit
    always_comb begin
        if (width_reg == '0) begin
            w_last = '0;
        end else if (width_reg > SCREEN_LIMIT) begin
            w_last = {LAST_W{1'b1}};
        end else begin
            w_last = LAST_W'(width_reg - COORD_W'(1));
        end
        if (height_reg == '0) begin
            h_last = '0;
        end else if (height_reg > SCREEN_LIMIT) begin
            h_last = {LAST_W{1'b1}};
        end else begin
            h_last = LAST_W'(height_reg - COORD_W'(1));
        end
    end

    // per-axis selection; an inverted window is swapped
    assign cmin_sel = axis_reg ? cal_y_min_reg : cal_x_min_reg;
    assign cmax_sel = axis_reg ? cal_y_max_reg : cal_x_max_reg;
    assign last_sel = axis_reg ? h_last : w_last;
    assign inv_sel  = cmin_sel > cmax_sel;
    assign lo       = inv_sel ? cmax_sel : cmin_sel;
    assign hi       = inv_sel ? cmin_sel : cmax_sel;
    assign avg      = quo_reg[COORD_W-1:0];

    // one restoring divide step
    assign trial    = {rem_reg, quo_reg[DIV_W-1]};
    assign trial_ge = trial >= {1'b0, den_reg};

    // quotient is |d|*last/(hi-lo), truncated; apply sign, window direction and clamp
    assign qsat = (quo_reg > DIV_W'(last_sel)) ? last_sel : quo_reg[LAST_W-1:0];
    always_comb begin
        if (zero_reg) begin
            map_res = '0;
        end else if (inv_reg) begin
            map_res = dneg_reg ? last_sel : (last_sel - qsat);
        end else begin
            map_res = dneg_reg ? '0 : qsat;
        end
    end

    always_comb begin
        case (rotation_reg)
            ROT_90: begin
                rx = sy_reg;          ry = w_last - sx_reg;
            end
            ROT_180: begin
                rx = w_last - sx_reg; ry = h_last - sy_reg;
            end
            ROT_270: begin
                rx = h_last - sy_reg; ry = sx_reg;
            end
            default: begin
                rx = sx_reg;          ry = sy_reg;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && done) begin
                    state_next = enough ? ST_AVG : ST_DONE;
                end
            end
            ST_AVG: begin
                if (cnt_div_end) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: state_next = ST_MUL;
            ST_MUL: begin
                if (cnt_mul_end) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (cnt_div_end) begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP: state_next = axis_reg ? ST_DONE : ST_AVG;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        idx_next      = idx_reg;
        vcnt_next     = vcnt_reg;
        sum_x_next    = sum_x_reg;
        sum_y_next    = sum_y_reg;
        good_next     = good_reg;
        axis_next     = axis_reg;
        cnt_next      = cnt_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        mcand_next    = mcand_reg;
        mlt_next      = mlt_reg;
        dneg_next     = dneg_reg;
        zero_next     = zero_reg;
        inv_next      = inv_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tuser_next  = m_tuser_reg;
        m_tdata_next  = m_tdata_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    idx_next   = idx_inc;
                    vcnt_next  = vcnt_acc;
                    sum_x_next = sum_x_acc;
                    sum_y_next = sum_y_acc;
                    good_next  = enough;
                    // start the X average
                    axis_next  = 1'b0;
                    quo_next   = DIV_W'(sum_x_acc);
                    rem_next   = '0;
                    den_next   = COORD_W'(vcnt_acc);
                    cnt_next   = '0;
                end
            end
            ST_AVG, ST_DIV: begin
                quo_next = {quo_reg[DIV_W-2:0], trial_ge};
                rem_next = trial_ge ? COORD_W'(trial - {1'b0, den_reg})
                                    : COORD_W'(trial);
                cnt_next = cnt_div_end ? '0 : cnt_reg + CNT_W'(1);
            end
            ST_SETUP: begin
                dneg_next  = avg < lo;
                mcand_next = (avg < lo) ? (lo - avg) : (avg - lo);
                mlt_next   = last_sel;
                den_next   = hi - lo;
                zero_next  = hi == lo;
                inv_next   = inv_sel;
                quo_next   = '0;
                cnt_next   = '0;
            end
            ST_MUL: begin
                // accumulate MSB first
                quo_next = {quo_reg[DIV_W-2:0], 1'b0}
                           + (mlt_reg[LAST_W-1] ? DIV_W'(mcand_reg) : DIV_W'(0));
                mlt_next = {mlt_reg[LAST_W-2:0], 1'b0};
                rem_next = '0;
                cnt_next = cnt_mul_end ? '0 : cnt_reg + CNT_W'(1);
            end
            ST_MAP: begin
                if (axis_reg) begin
                    sy_next = map_res;
                end else begin
                    sx_next   = map_res;
                    axis_next = 1'b1;
                    quo_next  = DIV_W'(sum_y_reg);
                    rem_next  = '0;
                    den_next  = COORD_W'(vcnt_reg);
                    cnt_next  = '0;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = good_reg;
                    m_tdata_next  = good_reg ? M_TDATA_W'({ry, rx}) : '0;
                    idx_next      = '0;
                    vcnt_next     = '0;
                    sum_x_next    = '0;
                    sum_y_next    = '0;
                    good_next     = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            vcnt_reg      <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            good_reg      <= 1'b0;
            axis_reg      <= 1'b0;
            cnt_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
            cal_x_min_reg <= RST_CAL_MIN;
            cal_x_max_reg <= RST_CAL_MAX;
            cal_y_min_reg <= RST_CAL_MIN;
            cal_y_max_reg <= RST_CAL_MAX;
            width_reg     <= RST_WIDTH;
            height_reg    <= RST_HEIGHT;
            rotation_reg  <= ROT_NONE;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            vcnt_reg     <= vcnt_next;
            sum_x_reg    <= sum_x_next;
            sum_y_reg    <= sum_y_next;
            good_reg     <= good_next;
            axis_reg     <= axis_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CAL_X_MIN:     cal_x_min_reg <= cfg_data;
                    REG_CAL_X_MAX:     cal_x_max_reg <= cfg_data;
                    REG_CAL_Y_MIN:     cal_y_min_reg <= cfg_data;
                    REG_CAL_Y_MAX:     cal_y_max_reg <= cfg_data;
                    REG_SCREEN_WIDTH:  width_reg     <= cfg_data;
                    REG_SCREEN_HEIGHT: height_reg    <= cfg_data;
                    REG_ROTATION:      rotation_reg  <= cfg_data[ROT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        den_reg     <= den_next;
        mcand_reg   <= mcand_next;
        mlt_reg     <= mlt_next;
        dneg_reg    <= dneg_next;
        zero_reg    <= zero_next;
        inv_reg     <= inv_next;
        sx_reg      <= sx_next;
        sy_reg      <= sy_next;
        m_tuser_reg <= m_tuser_next;
        m_tdata_reg <= m_tdata_next;
    end

    `ASSERT_IMPLY(a_invalid_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata == '0, "result without position carries non-zero coordinates")
    `ASSERT_IMPLY(a_count_bound, aclk, aresetn, 1'b1, (vcnt_reg <= idx_reg) && (idx_reg <= IDX_W'(SAMPLES_PER_REQUEST)), "sample counters out of range")
    `ASSERT_NEXT(a_state_cleared, aclk, aresetn, (state_reg == ST_DONE) && out_free, (idx_reg == '0) && (vcnt_reg == '0) && (sum_x_reg == '0) && (sum_y_reg == '0), "request state not cleared after result")

endmodule

// ===== verif/tb.sv =====
module tb;
    import tsam_pkg::*;

    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int END_WAIT        = 200;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 103;
    localparam int N_DIR           = 23;
    localparam int N_FIXED         = 5;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic        ok;
        logic [10:0] x;
        logic [10:0] y;
    } pos_result_t;

    typedef struct packed {
        logic        typed;
        pos_result_t want;
    } row_note_t;

    typedef struct packed {
        logic [11:0] p;
        logic [11:0] x;
        logic [11:0] y;
        logic        typed;
        logic        ok;
        logic [10:0] px;
        logic [10:0] py;
    } dir_row_t;

    typedef struct packed {
        logic [11:0] xl;
        logic [11:0] xh;
        logic [11:0] yl;
        logic [11:0] yh;
        logic [11:0] w;
        logic [11:0] h;
        logic [1:0]  r;
    } cal_set_t;

    // pressure, x, y, typed, position_valid, pos_x, pos_y
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        // release straight after reset, then release at the threshold
        '{12'd0,    12'd0,    12'd0,    1'b1, 1'b0, 11'd0,   11'd0},
        '{12'd100,  12'd4095, 12'd4095, 1'b1, 1'b0, 11'd0,   11'd0},
        // four samples on the window minimum, then on the maximum
        '{12'd4095, 12'd200,  12'd200,  1'b0, 1'b0, 11'd0,   11'd0},
        '{12'd4095, 12'd200,  12'd200,  1'b0, 1'b0, 11'd0,   11'd0},
        '{12'd4095, 12'd200,  12'd200,  1'b0, 1'b0, 11'd0,   11'd0},
        '{12'd4095, 12'd200,  12'd200,  1'b1, 1'b1, 11'd0,   11'd0},
        '{12'd101,  12'd3800, 12'd3800, 1'b0, 1'b0, 11'd0,   11'd0},
        '{12'd101,  12'd3800, 12'd3800, 1'b0, 1'b0, 11'd0,   11'd0},
        '{12'd101,  12'd3800, 12'd3800, 1'b0, 1'b0, 11'd0,   11'd0},
        '{12'd101,  12'd3800, 12'd3800, 1'b1, 1'b1, 11'd239, 11'd319},
        // coordinates on the validity bounds are all rejected
        '{12'd4095, 12'd100,  12'd2000, 1'b0, 1'b0, 11'd0,   11'd0},
        '{12'd4095, 12'd4000, 12'd2000, 1'b0, 1'b0, 11'd0,   11'd0},
        '{12'd4095, 12'd2000, 12'd100,  1'b0, 1'b0, 11'd0,   11'd0},
        '{12'd4095, 12'd2000, 12'd4000, 1'b1, 1'b0, 11'd0,   11'd0},
        // one valid sample is too few
        '{12'd4095, 12'd2000, 12'd2000, 1'b0, 1'b0, 11'd0,   11'd0},
        '{12'd0,    12'd4095, 12'd4095, 1'b1, 1'b0, 11'd0,   11'd0},
        '{12'd200,  12'd101,  12'd101,  1'b0, 1'b0, 11'd0,   11'd0},
        '{12'd200,  12'd3999, 12'd3999, 1'b0, 1'b0, 11'd0,   11'd0},
        '{12'd50,   12'd0,    12'd0,    1'b0, 1'b0, 11'd0,   11'd0},
        '{12'hAAA,  12'h555,  12'hAAA,  1'b0, 1'b0, 11'd0,   11'd0},
        '{12'h555,  12'hAAA,  12'h555,  1'b0, 1'b0, 11'd0,   11'd0},
        '{12'hFFF,  12'h001,  12'hFFE,  1'b0, 1'b0, 11'd0,   11'd0},
        '{12'h800,  12'h7FF,  12'h800,  1'b0, 1'b0, 11'd0,   11'd0}
    };

    // xl, xh, yl, yh, width, height, rotation
    localparam cal_set_t FIXED_CAL [N_FIXED] = '{
        '{12'd0,    12'd4095, 12'd0,    12'd4095, 12'd2048, 12'd2048, ROT_NONE},
        '{12'd4095, 12'd0,    12'd3800, 12'd200,  12'd240,  12'd320,  ROT_90},
        '{12'd2000, 12'd2000, 12'd0,    12'd0,    12'd1,    12'd1,    ROT_180},
        '{12'd2000, 12'd2001, 12'd1500, 12'd1501, 12'd4095, 12'd0,    ROT_270},
        '{12'd200,  12'd3800, 12'd200,  12'd3800, 12'd2048, 12'd1,    ROT_90}
    };

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // pressure_raw, sample_x, sample_y, zero pad
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // pos_x, pos_y, zero pad
    logic                 m_tuser;          // position_valid
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COORD_W-1:0]   cfg_data  = '0;

    logic full_rate = 1'b0;
    logic hold_arm  = 1'b0;
    logic hold_used = 1'b0;
    int   hold_left = 0;
    int   quiet     = 0;
    int   mismatches = 0;
    int   items_sent = 0;

    // predictor copy of registers and request state
    int         win_x_lo = 200, win_x_hi = 3800, win_y_lo = 200, win_y_hi = 3800;
    int         scr_w = 240, scr_h = 320;
    logic [1:0] rot = ROT_NONE;
    int         taken = 0, sum_x = 0, sum_y = 0, n_good = 0;

    pos_result_t pending_pos [$];
    row_note_t   row_notes   [$];

    touch_sample_average_map u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int clip_dim(int d);
        if (d == 0) return 1;
        if (d > 2048) return 2048;
        return d;
    endfunction

    function automatic int scale_axis(int v, int lo, int hi, int last);
        int     o0, o1, t;
        longint r;
        o0 = 0;
        o1 = last;
        // inverted window: swap the ends and mirror the axis
        if (lo > hi) begin
            t  = lo;
            lo = hi;
            hi = t;
            o0 = last;
            o1 = 0;
        end
        if (hi == lo) r = 0;
        else r = (longint'(v - lo) * longint'(o1 - o0)) / longint'(hi - lo) + o0;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        if (r < 0) r = 0;
        if (r > last) r = last;
        return int'(r);
    endfunction

    task automatic take_sample(input logic [11:0] p, input logic [11:0] x,
                               input logic [11:0] y, output bit ends,
                               output pos_result_t res);
        int w, h, sx, sy, rx, ry;
        res = '0;
        if (p <= TOUCH_THRESHOLD) begin
            ends = 1'b1;
        end else begin
            if (x > COORD_LOW && x < COORD_HIGH && y > COORD_LOW && y < COORD_HIGH) begin
                sum_x += x;
                sum_y += y;
                n_good++;
            end
            taken++;
            ends = (taken >= DEF_SAMPLES);
        end
        if (!ends) return;
        if (n_good >= MIN_VALID) begin
            w  = clip_dim(scr_w);
            h  = clip_dim(scr_h);
            sx = scale_axis(sum_x / n_good, win_x_lo, win_x_hi, w - 1);
            sy = scale_axis(sum_y / n_good, win_y_lo, win_y_hi, h - 1);
            case (rot)
                ROT_90: begin
                    rx = sy;
                    ry = w - 1 - sx;
                end
                ROT_180: begin
                    rx = w - 1 - sx;
                    ry = h - 1 - sy;
                end
                ROT_270: begin
                    rx = h - 1 - sy;
                    ry = sx;
                end
                default: begin
                    rx = sx;
                    ry = sy;
                end
            endcase
            res.ok = 1'b1;
            res.x  = 11'(rx);
            res.y  = 11'(ry);
        end
        taken  = 0;
        sum_x  = 0;
        sum_y  = 0;
        n_good = 0;
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("tb: %0t %s got %0d want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // check results, track register writes, predict on every accepted sample
    always @(posedge aclk) begin : mon
        pos_result_t got, want, calc;
        row_note_t   note;
        bit          ends;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[10:0], m_tdata[21:11]};
                if (pending_pos.size() == 0) begin
                    report_mismatch("unexpected result, pos_x", got.x, 0);
                end else begin
                    want = pending_pos.pop_front();
                    if (got.ok !== want.ok) report_mismatch("position_valid", got.ok, want.ok);
                    if (got.x !== want.x) report_mismatch("pos_x", got.x, want.x);
                    if (got.y !== want.y) report_mismatch("pos_y", got.y, want.y);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CAL_X_MIN:     win_x_lo = cfg_data;
                    REG_CAL_X_MAX:     win_x_hi = cfg_data;
                    REG_CAL_Y_MIN:     win_y_lo = cfg_data;
                    REG_CAL_Y_MAX:     win_y_hi = cfg_data;
                    REG_SCREEN_WIDTH:  scr_w    = cfg_data;
                    REG_SCREEN_HEIGHT: scr_h    = cfg_data;
                    REG_ROTATION:      rot      = cfg_data[1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                note = row_notes.pop_front();
                take_sample(s_tdata[11:0], s_tdata[23:12], s_tdata[35:24], ends, calc);
                if (ends) pending_pos.push_back(note.typed ? note.want : calc);
            end
        end
    end

    // receiver: random stalls, one long hold-off on request
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_arm && !hold_used) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else begin
            m_tready <= full_rate || ($urandom_range(99) >= 27);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet <= 0;
            end else if (quiet == WATCHDOG_LIMIT) begin
                $display("touch_sample_average_map: mismatch");
                $finish;
            end else begin
                quiet <= quiet + 1;
            end
        end
    end

    task automatic put_sample(logic [11:0] p, logic [11:0] x, logic [11:0] y,
                              row_note_t note);
        row_notes.push_back(note);
        s_tdata  <= {4'd0, y, x, p};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        while (!full_rate && $urandom_range(99) < 27) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    function automatic logic [11:0] touched_coord();
        if ($urandom_range(9) == 0) return 12'($urandom);
        return 12'($urandom_range(101, 3999));
    endfunction

    task automatic put_release();
        put_sample(12'($urandom_range(100)), 12'($urandom), 12'($urandom), '0);
    endtask

    task automatic send_request();
        int kind, n;
        kind = $urandom_range(99);
        if (kind < 65) begin
            repeat (DEF_SAMPLES)
                put_sample(12'($urandom_range(101, 4095)), touched_coord(), touched_coord(), '0);
        end else if (kind < 82) begin
            n = $urandom_range(DEF_SAMPLES - 1);
            repeat (n)
                put_sample(12'($urandom_range(101, 4095)), touched_coord(), touched_coord(), '0);
            put_release();
        end else begin
            put_sample(12'($urandom), 12'($urandom), 12'($urandom), '0);
        end
    endtask

    // hold the sender until every result is in and the block has gone quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_pos.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic load_cal(cal_set_t cs);
        write_reg(REG_CAL_X_MIN, cs.xl);
        write_reg(REG_CAL_X_MAX, cs.xh);
        write_reg(REG_CAL_Y_MIN, cs.yl);
        write_reg(REG_CAL_Y_MAX, cs.yh);
        write_reg(REG_SCREEN_WIDTH, cs.w);
        write_reg(REG_SCREEN_HEIGHT, cs.h);
        write_reg(REG_ROTATION, {10'($urandom), cs.r});
        write_reg(REG_UNUSED, 12'($urandom));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [11:0] random_dim();
        if ($urandom_range(7) == 0) return 12'($urandom);
        if ($urandom_range(3) == 0) return 12'($urandom_range(1, 16));
        return 12'($urandom_range(1, 2048));
    endfunction

    function automatic cal_set_t random_cal();
        cal_set_t cs;
        if ($urandom_range(1) == 0) begin
            cs.xl = 12'($urandom_range(1000));
            cs.xh = 12'($urandom_range(3000, 4095));
            cs.yl = 12'($urandom_range(1000));
            cs.yh = 12'($urandom_range(3000, 4095));
        end else begin
            cs.xl = 12'($urandom);
            cs.xh = 12'($urandom);
            cs.yl = 12'($urandom);
            cs.yh = 12'($urandom);
        end
        cs.w = random_dim();
        cs.h = random_dim();
        cs.r = 2'($urandom);
        return cs;
    endfunction

    initial begin
        row_note_t note;
        cal_set_t  cs;
        int        target;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIR; i++) begin
            note.typed   = DIR_ROWS[i].typed;
            note.want.ok = DIR_ROWS[i].ok;
            note.want.x  = DIR_ROWS[i].px;
            note.want.y  = DIR_ROWS[i].py;
            put_sample(DIR_ROWS[i].p, DIR_ROWS[i].x, DIR_ROWS[i].y, note);
        end
        settle();

        for (int ph = 0; ph < PHASES; ph++) begin
            cs = (ph < N_FIXED) ? FIXED_CAL[ph] : random_cal();
            load_cal(cs);
            full_rate <= (ph == 1 || ph == 2);
            if (ph == 2) begin
                // back-to-back releases against a stalled receiver fill the block
                hold_arm <= 1'b1;
                repeat (30) put_release();
            end
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target) send_request();
            put_release();
            settle();
        end

        repeat (END_WAIT) @(posedge aclk);
        if (mismatches == 0) begin
            $display("touch_sample_average_map: match");
        end else begin
            $display("touch_sample_average_map: mismatch");
        end
        $finish;
    end

endmodule

// ===== touch_sample_average_map.f =====
+incdir+src
src/tsam_pkg.sv
src/touch_sample_average_map.sv
verif/tb.sv
